### hdl/spq_pkg.sv
// shared types and constants for the sorted priority queue
`timescale 1ns / 1ps

package spq_pkg;

  // number of cells in the chain
  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // field widths
  localparam int ID_W    = 16;
  localparam int PRIO_W  = 16;
  localparam int COUNT_W = 5;

  typedef enum logic [1:0] {
    ACT_ENQUEUE = 2'd0,
    ACT_DEQUEUE = 2'd1,
    ACT_CHANGE  = 2'd2,
    ACT_FIND    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  // what every cell does in one cycle
  typedef enum logic [1:0] {
    OP_HOLD       = 2'd0,
    OP_INSERT     = 2'd1,
    OP_SHIFT_LEFT = 2'd2,
    OP_REMOVE     = 2'd3
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_INSERT = 2'd1,
    S_REPORT = 2'd2
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } slot_t;

  // broadcast from the controller to all cells
  typedef struct packed {
    cell_op_t op;
    slot_t    key;
  } cell_cmd_t;

  // flags rippling from cell to cell, head toward tail
  typedef struct packed {
    logic            gt;    // this cell outranks the key
    logic            seen;  // id match at or before this cell
    logic            fhit;  // priority match at or before this cell
    logic [ID_W-1:0] fid;   // id of the last priority match so far
  } chain_t;

endpackage

### hdl/spq_cell.sv
// one slot of the sorted chain: holds an entry and shifts with its neighbors
`timescale 1ns / 1ps

module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_cmd_t cmd,
  input  logic               valid,
  input  spq_pkg::slot_t     left,
  input  spq_pkg::slot_t     right,
  input  spq_pkg::chain_t    chain_in,
  output spq_pkg::slot_t     slot,
  output spq_pkg::chain_t    chain_out
);

  logic gt;
  logic id_hit;
  logic prio_hit;
  spq_pkg::slot_t slot_next;

  // compare own entry against the broadcast key
  assign gt       = valid && (slot.prio > cmd.key.prio);
  assign id_hit   = valid && (slot.id == cmd.key.id);
  assign prio_hit = valid && (slot.prio == cmd.key.prio);

  // pass flags on to the next cell
  always_comb begin
    chain_out.gt   = gt;
    chain_out.seen = chain_in.seen | id_hit;
    chain_out.fhit = chain_in.fhit | prio_hit;
    chain_out.fid  = prio_hit ? slot.id : chain_in.fid;
  end

  // pick the new content of this slot
  always_comb begin
    slot_next = slot;
    case (cmd.op)
      spq_pkg::OP_INSERT: begin
        if (gt) begin
          slot_next = slot;
        end else if (chain_in.gt) begin
          slot_next = cmd.key;
        end else begin
          slot_next = left;
        end
      end
      spq_pkg::OP_SHIFT_LEFT: begin
        slot_next = right;
      end
      spq_pkg::OP_REMOVE: begin
        if (chain_out.seen) begin
          slot_next = right;
        end
      end
      default: begin
        slot_next = slot;
      end
    endcase
  end

  // entry storage, no reset needed
  always_ff @(posedge clk) begin
    slot <= slot_next;
  end

endmodule

### hdl/sorted_priority_queue_top.sv
// sorted priority queue: controller and chain of entry cells
`timescale 1ns / 1ps
//
// Priority queue of up to 16 (id, priority) entries kept sorted in a chain
// of cells, highest priority at the head; ties put the newest entry first.
// Input channel s_*: s_tuser carries the action (enqueue, dequeue head,
// change priority, find by priority), s_tdata carries id and priority.
// Output channel m_*: one item per input item, with the status in m_tuser
// and the found id, head id, head priority, empty flag and count in m_tdata.
// An item is taken when tvalid and tready are both high.
// Enqueue and dequeue update the cells in the cycle the item is taken, and
// find only reads them; change priority removes the entry in that cycle and
// reinserts it in the next one. After the last cell update the result is
// loaded into the output register, which raises m_tvalid, and a new item
// can be taken in the same cycle its predecessor's result is loaded: one
// item per cycle while the receiver does not stall, though no new item is
// taken during the reinsert pass of change priority.
// Reset (rst, synchronous) empties the queue and drops any pending result.
// While the receiver stalls, the result stays in the output register, and
// the block takes at most one more item and holds it until the register
// frees up.

module sorted_priority_queue_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,   // action
  input  logic [31:0] s_tdata,   // entry_id, priority_req
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [1:0]  m_tuser,   // status
  output logic [55:0] m_tdata    // found_id, head_id, head_priority, is_empty, entry_count
);

  localparam int N = spq_pkg::CAPACITY;

  spq_pkg::state_t  state, state_next;
  logic [spq_pkg::CNT_W-1:0] count, count_next;
  spq_pkg::slot_t   pend, pend_next;
  spq_pkg::status_t res_status, res_status_next;
  logic [spq_pkg::ID_W-1:0] res_found, res_found_next;

  spq_pkg::cell_cmd_t cmd;
  spq_pkg::slot_t     slots [N];
  spq_pkg::chain_t    chains [N+1];
  logic [N-1:0]       valid;

  spq_pkg::slot_t in_slot;
  spq_pkg::action_t in_action;
  logic accept;
  logic out_free;
  logic full;
  logic empty;

  assign in_slot.id   = s_tdata[15:0];
  assign in_slot.prio = s_tdata[31:16];
  assign in_action    = spq_pkg::action_t'(s_tuser);

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == spq_pkg::S_IDLE) || (state == spq_pkg::S_REPORT && out_free);
  assign accept   = s_tvalid && s_tready;
  assign full     = (count == spq_pkg::CNT_W'(N));
  assign empty    = (count == '0);

  // head of the chain sees a key that outranks nothing
  always_comb begin
    chains[0].gt   = 1'b1;
    chains[0].seen = 1'b0;
    chains[0].fhit = 1'b0;
    chains[0].fid  = '0;
  end

  // row of cells
  for (genvar g = 0; g < N; g++) begin : g_cell
    spq_pkg::slot_t left_slot;
    spq_pkg::slot_t right_slot;

    assign valid[g] = (spq_pkg::CNT_W'(g) < count);

    if (g == 0) begin : g_first
      assign left_slot = '0;
    end else begin : g_mid
      assign left_slot = slots[g-1];
    end

    if (g == N-1) begin : g_last
      assign right_slot = '0;
    end else begin : g_inner
      assign right_slot = slots[g+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .valid     (valid[g]),
      .left      (left_slot),
      .right     (right_slot),
      .chain_in  (chains[g]),
      .slot      (slots[g]),
      .chain_out (chains[g+1])
    );
  end

  // state register and control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spq_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    pend       <= pend_next;
    res_status <= res_status_next;
    res_found  <= res_found_next;
  end

  // next state, cell command and result capture
  always_comb begin
    state_next      = state;
    count_next      = count;
    pend_next       = pend;
    res_status_next = res_status;
    res_found_next  = res_found;
    cmd.op          = spq_pkg::OP_HOLD;
    cmd.key         = in_slot;

    case (state)
      spq_pkg::S_INSERT: begin
        cmd.op     = spq_pkg::OP_INSERT;
        cmd.key    = pend;
        count_next = count + spq_pkg::CNT_W'(1);
        state_next = spq_pkg::S_REPORT;
      end
      spq_pkg::S_REPORT: begin
        if (out_free && !accept) begin
          state_next = spq_pkg::S_IDLE;
        end
      end
      default: begin
      end
    endcase

    // a new item starts its first cell update here
    if (accept) begin
      res_status_next = spq_pkg::STAT_OK;
      res_found_next  = '0;
      state_next      = spq_pkg::S_REPORT;
      case (in_action)
        spq_pkg::ACT_ENQUEUE: begin
          if (full) begin
            res_status_next = spq_pkg::STAT_FULL;
          end else begin
            cmd.op     = spq_pkg::OP_INSERT;
            count_next = count + spq_pkg::CNT_W'(1);
          end
        end
        spq_pkg::ACT_DEQUEUE: begin
          if (empty) begin
            res_status_next = spq_pkg::STAT_EMPTY;
          end else begin
            cmd.op     = spq_pkg::OP_SHIFT_LEFT;
            count_next = count - spq_pkg::CNT_W'(1);
          end
        end
        spq_pkg::ACT_CHANGE: begin
          if (chains[N].seen) begin
            cmd.op     = spq_pkg::OP_REMOVE;
            count_next = count - spq_pkg::CNT_W'(1);
            pend_next  = in_slot;
            state_next = spq_pkg::S_INSERT;
          end else begin
            res_status_next = spq_pkg::STAT_NOT_FOUND;
          end
        end
        default: begin
          if (chains[N].fhit) begin
            res_found_next = chains[N].fid;
          end else begin
            res_status_next = spq_pkg::STAT_NOT_FOUND;
          end
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == spq_pkg::S_REPORT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == spq_pkg::S_REPORT && out_free) begin
      m_tuser         <= res_status;
      m_tdata[15:0]   <= res_found;
      m_tdata[31:16]  <= empty ? '0 : slots[0].id;
      m_tdata[47:32]  <= empty ? '0 : slots[0].prio;
      m_tdata[48]     <= empty;
      m_tdata[53:49]  <= spq_pkg::COUNT_W'(count);
      m_tdata[55:54]  <= 2'b00;
    end
  end

endmodule

### hdl/spq_checker.sv
// port-level checks for the sorted priority queue, bound to the top level
`timescale 1ns / 1ps

module spq_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic [1:0]  m_tuser,
  input logic [55:0] m_tdata
);

  // no result is shown right after reset
  a_reset_clears: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

  // empty flag agrees with the count
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[48] == (m_tdata[53:49] == 5'd0)))
    else $error("empty flag and count disagree");

  // an empty queue shows a zero head
  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[48]) |-> (m_tdata[31:16] == 16'd0 && m_tdata[47:32] == 16'd0))
    else $error("empty queue shows a head entry");

  // found id only accompanies a good status
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != spq_pkg::STAT_OK) |-> (m_tdata[15:0] == 16'd0))
    else $error("found id set on a failed item");

  // count never exceeds the capacity
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[53:49] <= 5'(spq_pkg::CAPACITY)))
    else $error("count above capacity");

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tuser  (m_tuser),
  .m_tdata  (m_tdata)
);

### tb/sorted_priority_queue_top_test.sv
// testbench for the sorted priority queue: directed and random actions checked against a mirror
`timescale 1ns / 1ps

module sorted_priority_queue_top_test;
  import spq_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_CYCLES     = 300;
  localparam int ITEMS_PER_PHASE = 430;
  localparam int DRAIN_CYCLES    = 20;

  // one expected result item
  typedef struct {
    status_t            status;
    logic [ID_W-1:0]    found_id;
    logic [ID_W-1:0]    head_id;
    logic [PRIO_W-1:0]  head_prio;
    logic               is_empty;
    logic [COUNT_W-1:0] count;
  } queue_report_t;

  // mirror of the sorted list plus the reports it predicts
  class queue_mirror;
    logic [ID_W-1:0]   slot_id [CAPACITY];
    logic [PRIO_W-1:0] slot_prio [CAPACITY];
    int                occ;
    int                errors;
    queue_report_t     reports [$];

    function new();
      occ    = 0;
      errors = 0;
    endfunction

    // close the gap at pos
    function void remove_entry(int pos);
      for (int i = pos; i + 1 < occ; i++) begin
        slot_id[i]   = slot_id[i + 1];
        slot_prio[i] = slot_prio[i + 1];
      end
      occ--;
    endfunction

    // insert ahead of the first entry that does not outrank it
    function void insert_entry(logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio);
      int pos;
      pos = 0;
      while (pos < occ && slot_prio[pos] > prio) pos++;
      for (int i = occ; i > pos; i--) begin
        slot_id[i]   = slot_id[i - 1];
        slot_prio[i] = slot_prio[i - 1];
      end
      slot_id[pos]   = id;
      slot_prio[pos] = prio;
      occ++;
    endfunction

    // apply one accepted action and queue the report it should produce
    function void note_action(action_t act, logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio);
      queue_report_t r;
      int            pos;
      bit            hit;
      r.status   = STAT_OK;
      r.found_id = '0;
      hit        = 1'b0;
      pos        = 0;
      case (act)
        ACT_ENQUEUE: begin
          if (occ >= CAPACITY) r.status = STAT_FULL;
          else insert_entry(id, prio);
        end
        ACT_DEQUEUE: begin
          if (occ == 0) r.status = STAT_EMPTY;
          else remove_entry(0);
        end
        ACT_CHANGE: begin
          // only the first id match moves
          while (pos < occ && !hit) begin
            if (slot_id[pos] == id) hit = 1'b1;
            else pos++;
          end
          if (!hit) begin
            r.status = STAT_NOT_FOUND;
          end else begin
            remove_entry(pos);
            insert_entry(id, prio);
          end
        end
        default: begin
          // last priority match in queue order wins
          for (int i = 0; i < occ; i++) begin
            if (slot_prio[i] == prio) begin
              r.found_id = slot_id[i];
              hit        = 1'b1;
            end
          end
          if (!hit) r.status = STAT_NOT_FOUND;
        end
      endcase
      r.head_id   = (occ != 0) ? slot_id[0] : '0;
      r.head_prio = (occ != 0) ? slot_prio[0] : '0;
      r.is_empty  = (occ == 0);
      r.count     = occ[COUNT_W-1:0];
      reports.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %h actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    // compare one result item with the oldest report
    function void check_result(status_t st, logic [55:0] data);
      queue_report_t want;
      if (reports.size() == 0) begin
        $display("%0t: result with none expected, expected none actual status %h data %h",
                 $time, st, data);
        errors++;
        return;
      end
      want = reports.pop_front();
      compare_field("status", 32'(want.status), 32'(st));
      compare_field("found_id", 32'(want.found_id), 32'(data[15:0]));
      compare_field("head_id", 32'(want.head_id), 32'(data[31:16]));
      compare_field("head_priority", 32'(want.head_prio), 32'(data[47:32]));
      compare_field("is_empty", 32'(want.is_empty), 32'(data[48]));
      compare_field("entry_count", 32'(want.count), 32'(data[53:49]));
    endfunction
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [1:0]  s_tuser  = ACT_ENQUEUE;  // action
  logic [31:0] s_tdata  = '0;           // entry_id, priority_req
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [1:0]  m_tuser;                 // status
  logic [55:0] m_tdata;                 // found_id, head_id, head_priority, is_empty, entry_count

  queue_mirror sb;
  int          idle_pct      = 0;
  int          stall_pct     = 0;
  int          hold_requests = 0;
  int          hold_served   = 0;
  int          hold_left     = 0;
  int          cycle_count   = 0;
  bit          filling       = 1'b1;

  sorted_priority_queue_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sorted_priority_queue_top_test: errors");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off when requested
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      m_tready    <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(status_t'(m_tuser), m_tdata);
  end

  // offer one item after a random gap and wait until it is taken
  task automatic send_item(action_t act, logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {prio, id};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_action(act, id, prio);
  endtask

  // mostly sweeps between empty and full with ids and priorities that collide
  task automatic pick_random(output action_t act, output logic [ID_W-1:0] id,
                             output logic [PRIO_W-1:0] prio);
    int unsigned roll;
    roll = $urandom_range(99);
    id   = 16'($urandom_range(0, 23));
    prio = 16'($urandom_range(0, 7));
    if ($urandom_range(99) < 20) id = 16'($urandom);
    if ($urandom_range(99) < 15) prio = 16'($urandom);
    if ($urandom_range(99) < 4) prio = {PRIO_W{roll[0]}};
    if (sb.occ >= CAPACITY) filling = 1'b0;
    if (sb.occ == 0) filling = 1'b1;
    if (roll < 5) begin
      act  = action_t'($urandom_range(3));
      id   = 16'($urandom);
      prio = 16'($urandom);
    end else if (roll < (filling ? 55 : 20)) begin
      act = ACT_ENQUEUE;
    end else if (roll < 65) begin
      act = ACT_DEQUEUE;
    end else if (roll < 83) begin
      act = ACT_CHANGE;
      if (sb.occ > 0 && $urandom_range(99) < 70) id = sb.slot_id[$urandom_range(sb.occ - 1)];
    end else begin
      act = ACT_FIND;
      if (sb.occ > 0 && $urandom_range(99) < 70) prio = sb.slot_prio[$urandom_range(sb.occ - 1)];
    end
  endtask

  initial begin
    action_t           act;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // empty queue cases
    send_item(ACT_DEQUEUE, 16'h0000, 16'h0000);
    send_item(ACT_FIND,    16'h0000, 16'h0005);
    send_item(ACT_CHANGE,  16'h0001, 16'h0010);
    // field extremes and a tie, newest first
    send_item(ACT_ENQUEUE, 16'h0000, 16'h0000);
    send_item(ACT_ENQUEUE, 16'hFFFF, 16'hFFFF);
    send_item(ACT_ENQUEUE, 16'h1111, 16'h0100);
    send_item(ACT_ENQUEUE, 16'h2222, 16'h0100);
    // fill to capacity, with a duplicate id
    for (int i = 0; i < CAPACITY - 4; i++) begin
      id = (i == 5) ? 16'h1111 : 16'h0A00 + 16'(i);
      send_item(ACT_ENQUEUE, id, 16'h0080 + 16'(i % 3) * 16'h0040);
    end
    send_item(ACT_ENQUEUE, 16'hABCD, 16'h8000);
    // find hit and miss, change on duplicate and absent id, dequeue
    send_item(ACT_FIND,    16'h0000, 16'h0100);
    send_item(ACT_FIND,    16'h0000, 16'h1234);
    send_item(ACT_CHANGE,  16'h1111, 16'hFFFF);
    send_item(ACT_CHANGE,  16'h7777, 16'h0001);
    send_item(ACT_DEQUEUE, 16'h0000, 16'h0000);

    // random phases with different idling
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 66;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 66;
        end
        default: begin
          idle_pct  = 34;
          stall_pct = 34;
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase == 0 && n == 100) hold_requests++;
        pick_random(act, id, prio);
        send_item(act, id, prio);
      end
    end
    s_tvalid <= 1'b0;

    // drain
    idle_pct  = 0;
    stall_pct = 0;
    while (sb.reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.reports.size() == 0) begin
      $display("sorted_priority_queue_top_test: clean");
    end else begin
      $display("sorted_priority_queue_top_test: errors");
    end
    $finish;
  end

endmodule

### sim.f
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue_top.sv
hdl/spq_checker.sv
tb/sorted_priority_queue_top_test.sv
